### src/lsb_first_bit_field_reader_macros.svh
// Assertion macros used by the checker of the bit field reader.
// Depends on a clk and an arst_n signal in the scope where the macros are used.
`ifndef LSB_FIRST_BIT_FIELD_READER_MACROS_SVH
`define LSB_FIRST_BIT_FIELD_READER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFBR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFBR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/lfbr_pkg.sv
// Package of the LSB-first bit field reader: sizes, request and status codes, shared types.
// Used by the byte store, the top level and the checker; it depends on nothing else.
package lfbr_pkg;

	localparam int BUF_BYTES      = 256;
	localparam int MAX_FIELD_BITS = 32;

	localparam int ADDR_W  = $clog2(BUF_BYTES);
	localparam int LEN_W   = $clog2(BUF_BYTES + 1);
	localparam int POS_W   = LEN_W + 3;
	localparam int ROW_W   = ADDR_W - 3;
	localparam int ROWS    = BUF_BYTES / 8;
	localparam int CNT_W   = 6;
	localparam int VALUE_W = 32;
	localparam int OFF_W   = 5;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_READ   = 2'd2,
		REQ_ALIGN  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_EOD  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_FETCH
	} fsm_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] pos;
	} rd_req_t;

endpackage

### src/lfbr_store.sv
// Byte store of the bit field reader: two word banks, even and odd words, byte writable.
// A read fetches the word at a bit position and the word after it. Uses lfbr_pkg.
module lfbr_store (
	input  logic                                clk,
	input  lfbr_pkg::wr_req_t                   wr,
	input  lfbr_pkg::rd_req_t                   rd,
	output logic [lfbr_pkg::VALUE_W-1:0]        window
);

	logic [3:0][7:0] mem_even [lfbr_pkg::ROWS];
	logic [3:0][7:0] mem_odd  [lfbr_pkg::ROWS];

	logic [lfbr_pkg::POS_W-6:0]   rd_word;
	logic [lfbr_pkg::ROW_W-1:0]   rd_row;
	logic [lfbr_pkg::ROW_W-1:0]   rd_row_even;
	logic [lfbr_pkg::ROW_W-1:0]   wr_row;
	logic [31:0]                  even_s1;
	logic [31:0]                  odd_s1;
	logic                         odd_first_s1;
	logic [lfbr_pkg::OFF_W-1:0]   off_s1;
	logic [63:0]                  pair;
	logic [63:0]                  shifted;

	assign rd_word     = rd.pos[lfbr_pkg::POS_W-1:5];
	assign rd_row      = rd_word[lfbr_pkg::ROW_W:1];
	assign rd_row_even = rd_word[0] ? rd_row + 1'b1 : rd_row;
	assign wr_row      = wr.addr[lfbr_pkg::ADDR_W-1:3];

	always_ff @(posedge clk) begin
		if (wr.en && !wr.addr[2]) begin
			mem_even[wr_row][wr.addr[1:0]] <= wr.data;
		end
		if (wr.en && wr.addr[2]) begin
			mem_odd[wr_row][wr.addr[1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			even_s1      <= mem_even[rd_row_even];
			odd_s1       <= mem_odd[rd_row];
			odd_first_s1 <= rd_word[0];
			off_s1       <= rd.pos[lfbr_pkg::OFF_W-1:0];
		end
	end

	assign pair    = odd_first_s1 ? {even_s1, odd_s1} : {odd_s1, even_s1};
	assign shifted = pair >> off_s1;
	assign window  = shifted[lfbr_pkg::VALUE_W-1:0];

endmodule

### src/lsb_first_bit_field_reader.sv
// Top level of the LSB-first bit field reader: request decode, length and position, result register.
// Uses lfbr_pkg and the banked byte store lfbr_store.
//
// The slave channel s_* carries one request per transaction: clear, append a byte, read a field
// of 0 to 32 bits or align to the next byte boundary. The master channel m_* returns exactly one
// result per request, in request order, with the field value, a status and the bits remaining.
// Clear, append and align take one cycle: the result is valid in the cycle after acceptance.
// A read issues one word read to each of the two store banks on acceptance; in the fetch state it
// shifts the returned pair into place, masks it and moves the read position if enough bits remain.
// Up to 256 bytes are held; an append beyond that reports buffer full and changes nothing.
// A request is taken only while no read is in flight and the result register is free or being
// emptied in the same cycle, so a stalled receiver holds the result and stops new requests.
// Reset empties the stream and drops any pending result; the store itself is never cleared.
module lsb_first_bit_field_reader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // req_type[1:0], byte_in[9:2], bit_count[15:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // field_value[31:0], status[33:32], bits_remaining[45:34]
);

	localparam int POS_W   = lfbr_pkg::POS_W;
	localparam int LEN_W   = lfbr_pkg::LEN_W;
	localparam int CNT_W   = lfbr_pkg::CNT_W;
	localparam int VALUE_W = lfbr_pkg::VALUE_W;

	lfbr_pkg::fsm_t    state_q;
	lfbr_pkg::fsm_t    state_d;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_d;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_d;
	logic              out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [1:0]        out_status_q;
	logic [POS_W-1:0]  out_rem_q;
	logic              load;
	logic [VALUE_W-1:0] res_value;
	lfbr_pkg::status_t res_status;
	logic [POS_W-1:0]  res_rem;

	logic [CNT_W-1:0]  cnt_s1;
	logic              eod_s1;
	logic [POS_W-1:0]  rem_s1;

	lfbr_pkg::req_t    req;
	logic [7:0]        byte_in;
	logic [CNT_W-1:0]  bit_count;
	logic [CNT_W-1:0]  cnt_sat;
	logic [POS_W-1:0]  rem_now;
	logic [POS_W-1:0]  pos_aligned;
	logic              accept;
	logic              out_free;
	logic [VALUE_W-1:0] window;
	logic [VALUE_W-1:0] mask;
	lfbr_pkg::wr_req_t wr;
	lfbr_pkg::rd_req_t rd;

	assign req       = lfbr_pkg::req_t'(s_tdata[1:0]);
	assign byte_in   = s_tdata[9:2];
	assign bit_count = s_tdata[15:10];
	assign cnt_sat   = (bit_count > CNT_W'(lfbr_pkg::MAX_FIELD_BITS))
	                   ? CNT_W'(lfbr_pkg::MAX_FIELD_BITS) : bit_count;
	assign rem_now   = {len_q, 3'b000} - pos_q;
	assign pos_aligned = (pos_q[2:0] != 3'b000) ? {pos_q[POS_W-1:3] + 1'b1, 3'b000} : pos_q;
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == lfbr_pkg::FSM_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign mask      = (cnt_s1 >= CNT_W'(VALUE_W)) ? '1 : (VALUE_W'(1) << cnt_s1) - 1'b1;

	assign wr.en   = accept && (req == lfbr_pkg::REQ_APPEND) && (len_q < LEN_W'(lfbr_pkg::BUF_BYTES));
	assign wr.addr = len_q[lfbr_pkg::ADDR_W-1:0];
	assign wr.data = byte_in;
	assign rd.en   = accept && (req == lfbr_pkg::REQ_READ);
	assign rd.pos  = pos_q;

	lfbr_store u_store (
		.clk    (clk),
		.wr     (wr),
		.rd     (rd),
		.window (window)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfbr_pkg::FSM_IDLE: begin
				if (rd.en) begin
					state_d = lfbr_pkg::FSM_FETCH;
				end
			end
			lfbr_pkg::FSM_FETCH: begin
				state_d = lfbr_pkg::FSM_IDLE;
			end
			default: begin
				state_d = lfbr_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		load       = 1'b0;
		len_d      = len_q;
		pos_d      = pos_q;
		res_value  = '0;
		res_status = lfbr_pkg::ST_OK;
		res_rem    = rem_now;
		unique case (state_q)
			lfbr_pkg::FSM_IDLE: begin
				if (accept) begin
					unique case (req)
						lfbr_pkg::REQ_CLEAR: begin
							load    = 1'b1;
							len_d   = '0;
							pos_d   = '0;
							res_rem = '0;
						end
						lfbr_pkg::REQ_APPEND: begin
							load = 1'b1;
							if (wr.en) begin
								len_d   = len_q + 1'b1;
								res_rem = rem_now + POS_W'(8);
							end else begin
								res_status = lfbr_pkg::ST_FULL;
							end
						end
						lfbr_pkg::REQ_ALIGN: begin
							load    = 1'b1;
							pos_d   = pos_aligned;
							res_rem = {len_q, 3'b000} - pos_aligned;
						end
						lfbr_pkg::REQ_READ: begin
							load = 1'b0;
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			lfbr_pkg::FSM_FETCH: begin
				load = 1'b1;
				if (eod_s1) begin
					res_status = lfbr_pkg::ST_EOD;
					res_rem    = rem_s1;
				end else begin
					res_value = window & mask;
					pos_d     = pos_q + POS_W'(cnt_s1);
					res_rem   = rem_s1 - POS_W'(cnt_s1);
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfbr_pkg::FSM_IDLE;
			len_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			cnt_s1 <= cnt_sat;
			eod_s1 <= POS_W'(cnt_sat) > rem_now;
			rem_s1 <= rem_now;
		end
		if (load) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
			out_rem_q    <= res_rem;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_rem_q, out_status_q, out_value_q};

endmodule

### src/lfbr_checker.sv
// Port-level checker of the bit field reader, attached to the top level by a bind statement.
// Uses lfbr_pkg and the assertion macros of lsb_first_bit_field_reader_macros.svh.
`include "lsb_first_bit_field_reader_macros.svh"

module lfbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	logic [31:0] value_f;
	logic [1:0]  status_f;
	logic [11:0] rem_f;
	logic        clear_fire;

	assign value_f    = m_tdata[31:0];
	assign status_f   = m_tdata[33:32];
	assign rem_f      = m_tdata[45:34];
	assign clear_fire = s_tvalid && s_tready && (s_tdata[1:0] == lfbr_pkg::REQ_CLEAR);

	`LFBR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stall lost.")
	`LFBR_ASSERT_SAME(a_status_code, m_tvalid, status_f <= lfbr_pkg::ST_FULL, "Bad status.")
	`LFBR_ASSERT_SAME(a_rem_range, m_tvalid, rem_f <= 12'd2048, "Remaining bits too large.")
	`LFBR_ASSERT_SAME(a_err_zero, m_tvalid && status_f != lfbr_pkg::ST_OK, value_f == '0, "Bad value.")
	`LFBR_ASSERT_NEXT(a_clear_result, clear_fire, m_tvalid && rem_f == 12'd0, "Clear not empty.")

endmodule

bind lsb_first_bit_field_reader lfbr_checker u_lfbr_checker (.*);
